>>> src/heading_to_wheel_speeds_macros.svh
`ifndef HEADING_TO_WHEEL_SPEEDS_MACROS_SVH
`define HEADING_TO_WHEEL_SPEEDS_MACROS_SVH

// Checks run on i_clk and stay quiet while i_rst_n is low.
`define HWS_ASSERT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("heading_to_wheel_speeds check failed");

// Invariant that holds at every edge out of reset.
`define HWS_ALWAYS(lbl, c) `HWS_ASSERT(lbl, 1'b1, c)

`endif

>>> src/hws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hws_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

    localparam int XW   = 28;   // CORDIC x/y datapath
    localparam int ZW   = 24;   // CORDIC angle accumulator, Q.20
    localparam int PW   = 57;   // length product width
    localparam int LW   = 19;   // length, unsigned integer (Q19.0)
    localparam int SW   = 15;   // speed and threshold registers
    localparam int QW   = 16;   // quotient bits of the turn divider
    localparam int RW   = 32;   // divider remainder width

    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q13 = 12868;
    localparam int HALF_PI_Q20 = 1647099;
    localparam int GAIN_Q30    = 652032874;

    localparam int MID_DEPTH = 32;
    localparam int MID_AW    = 5;
    localparam int MID_CW    = MID_AW + 1;
    localparam int OUT_DEPTH = 32;
    localparam int OUT_AW    = 5;
    localparam int OUT_CW    = OUT_AW + 1;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_SOFT     = 2'd1,
        MODE_HARD     = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_NO_TURN   = 2'd1,
        CFG_SOFT_THR  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SW-1:0] max_speed;
        logic [SW-1:0] no_turn;
        logic [SW-1:0] soft_thr;
    } t_cfg;

    typedef struct packed {
        logic [SW-1:0] base;
        logic [SW-1:0] mag;
        t_mode         mode;
        logic          pos;
    } t_mid;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        t_mode              mode;
    } t_res;

    // arctangent of 2^-i in Q.20, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(823550);
            1:  v = ZW'(486170);
            2:  v = ZW'(256879);
            3:  v = ZW'(130396);
            4:  v = ZW'(65451);
            5:  v = ZW'(32757);
            6:  v = ZW'(16383);
            7:  v = ZW'(8192);
            8:  v = ZW'(4096);
            9:  v = ZW'(2048);
            10: v = ZW'(1024);
            11: v = ZW'(512);
            12: v = ZW'(256);
            13: v = ZW'(128);
            14: v = ZW'(64);
            15: v = ZW'(32);
            16: v = ZW'(16);
            17: v = ZW'(8);
            18: v = ZW'(4);
            19: v = ZW'(2);
            20: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/hws_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hws_front import hws_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] i_heading_x,
    input  wire logic signed [15:0] i_heading_y,
    output logic                    o_mid_push,
    output t_mid                    o_mid_data,
    input  wire logic               i_mid_pop
);

    localparam logic signed [ZW-1:0] HALF_Z  = ZW'(HALF_PI_Q20);
    localparam logic signed [ZW-1:0] PI_Z    = ZW'(PI_Q13);
    localparam logic signed [ZW-1:0] TWOPI_Z = ZW'(2 * PI_Q13);
    localparam logic signed [15:0]   PI_A    = 16'(PI_Q13);
    localparam logic signed [15:0]   HALF_A  = 16'(HALF_PI_Q13);
    localparam logic [PW-1:0]        GAIN    = PW'(GAIN_Q30);
    localparam logic [PW-1:0]        LEN_RND = PW'(1) << 37;

    logic accept;
    logic [MID_CW-1:0] r_cnt, n_cnt;

    assign full   = (r_cnt == MID_CW'(MID_DEPTH));
    assign accept = push && !full;
    assign n_cnt  = r_cnt + MID_CW'(accept) - MID_CW'(i_mid_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // entry: axis cases bypass the rotator, others fold into the right half plane
    logic signed [16:0] xe, ye, cx0, cy0;
    logic signed [ZW-1:0] z0;
    logic y_zero, x_zero;
    logic signed [15:0] sang0;
    logic [16:0] slen0;

    always_comb begin
        xe     = 17'(i_heading_x);
        ye     = 17'(i_heading_y);
        y_zero = (i_heading_y == 16'sd0);
        x_zero = (i_heading_x == 16'sd0);
        if (y_zero) begin
            sang0 = xe[16] ? -PI_A : 16'sd0;
            slen0 = xe[16] ? 17'(-xe) : 17'(xe);
        end else begin
            sang0 = ye[16] ? -HALF_A : HALF_A;
            slen0 = ye[16] ? 17'(-ye) : 17'(ye);
        end
        if (xe[16]) begin
            if (!ye[16]) begin
                cx0 = ye;
                cy0 = -xe;
                z0  = HALF_Z;
            end else begin
                cx0 = -ye;
                cy0 = xe;
                z0  = -HALF_Z;
            end
        end else begin
            cx0 = xe;
            cy0 = ye;
            z0  = '0;
        end
    end

    logic                 r_v    [0:CORDIC_N];
    logic signed [XW-1:0] r_cx   [0:CORDIC_N];
    logic signed [XW-1:0] r_cy   [0:CORDIC_N];
    logic signed [ZW-1:0] r_z    [0:CORDIC_N];
    logic                 r_spec [0:CORDIC_N];
    logic signed [15:0]   r_sang [0:CORDIC_N];
    logic [16:0]          r_slen [0:CORDIC_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= CORDIC_N; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v[0] <= accept;
            for (int i = 0; i < CORDIC_N; i++) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0]   <= XW'(cx0) <<< 8;
        r_cy[0]   <= XW'(cy0) <<< 8;
        r_z[0]    <= z0;
        r_spec[0] <= y_zero || x_zero;
        r_sang[0] <= sang0;
        r_slen[0] <= slen0;
        for (int i = 0; i < CORDIC_N; i++) begin
            if (r_cy[i] >= 0) begin
                r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                r_z[i+1]  <= r_z[i] + atan_q20(i);
            end else begin
                r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                r_z[i+1]  <= r_z[i] - atan_q20(i);
            end
            r_spec[i+1] <= r_spec[i];
            r_sang[i+1] <= r_sang[i];
            r_slen[i+1] <= r_slen[i];
        end
    end

    // round angle to Q3.13 and wrap into [-pi, pi); scale length by the CORDIC gain
    logic signed [ZW-1:0] zr;
    logic signed [15:0]   ang_w;
    logic [XW-2:0]        cxp;

    always_comb begin
        zr = (r_z[CORDIC_N] + ZW'(64)) >>> 7;
        if (zr >= PI_Z) begin
            zr = zr - TWOPI_Z;
        end else if (zr < -PI_Z) begin
            zr = zr + TWOPI_Z;
        end
        ang_w = zr[15:0];
        cxp   = r_cx[CORDIC_N][XW-1] ? '0 : r_cx[CORDIC_N][XW-2:0];
    end

    logic               r_pv;
    logic signed [15:0] r_pa;
    logic [PW-1:0]      r_prod;
    logic               r_pspec;
    logic signed [15:0] r_psang;
    logic [16:0]        r_pslen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= r_v[CORDIC_N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa    <= ang_w;
        r_prod  <= PW'(cxp) * GAIN;
        r_pspec <= r_spec[CORDIC_N];
        r_psang <= r_sang[CORDIC_N];
        r_pslen <= r_slen[CORDIC_N];
    end

    // classify
    logic [PW-1:0]      len_sum;
    logic [LW-1:0]      len;
    logic signed [15:0] ang;
    logic [15:0]        mag16;

    always_comb begin
        len_sum = r_prod + LEN_RND;
        len     = r_pspec ? LW'(r_pslen) : len_sum[PW-1:38];
        ang     = r_pspec ? r_psang : r_pa;
        mag16   = ang[15] ? 16'(-ang) : 16'(ang);
        o_mid_data.base = (len < LW'(i_cfg.max_speed)) ? len[SW-1:0] : i_cfg.max_speed;
        o_mid_data.mag  = mag16[SW-1:0];
        if (mag16[SW-1:0] <= i_cfg.no_turn) begin
            o_mid_data.mode = MODE_STRAIGHT;
        end else if (mag16[SW-1:0] <= i_cfg.soft_thr) begin
            o_mid_data.mode = MODE_SOFT;
        end else begin
            o_mid_data.mode = MODE_HARD;
        end
        o_mid_data.pos = (ang > 16'sd0);
    end

    assign o_mid_push = r_pv;

endmodule

`default_nettype wire

>>> src/hws_mid_q.sv
`timescale 1ns / 1ps
`default_nettype none

module hws_mid_q import hws_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_mid i_data,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_mid      o_data
);

    t_mid r_mem [0:MID_DEPTH-1];
    logic [MID_AW-1:0] r_wp, r_rp, n_rp;
    logic [MID_CW-1:0] r_cnt;
    t_mid r_rdata;

    assign n_rp = i_pop ? r_rp + MID_AW'(1) : r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + MID_AW'(1);
            end
            r_rp  <= n_rp;
            r_cnt <= r_cnt + MID_CW'(i_push) - MID_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        // prefetch the next head; a write into that slot goes straight through
        if (i_push && (r_wp == n_rp)) begin
            r_rdata <= i_data;
        end else begin
            r_rdata <= r_mem[n_rp];
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_rdata;

endmodule

`default_nettype wire

>>> src/hws_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "heading_to_wheel_speeds_macros.svh"

module hws_back import hws_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cfg         i_cfg,
    input  wire logic         i_mid_empty,
    input  wire t_mid         i_mid_data,
    output logic              o_mid_pop,
    input  wire logic         pop,
    output logic              empty,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic [1:0]        o_turn_mode
);

    logic out_pop;
    logic [OUT_CW-1:0] r_bcnt;

    assign o_mid_pop = !i_mid_empty && (r_bcnt != OUT_CW'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
        end else begin
            r_bcnt <= r_bcnt + OUT_CW'(o_mid_pop) - OUT_CW'(out_pop);
        end
    end

    // numerators 2*base*(T -/+ |a|) + T over divisor 2*T
    logic [SW-1:0]   dif;
    logic [SW:0]     sum;
    logic [2*SW-1:0] p_in;
    logic [2*SW:0]   p_out;

    always_comb begin
        dif   = (i_cfg.soft_thr >= i_mid_data.mag) ? i_cfg.soft_thr - i_mid_data.mag : '0;
        sum   = (SW+1)'(i_cfg.soft_thr) + (SW+1)'(i_mid_data.mag);
        p_in  = (2*SW)'(i_mid_data.base) * (2*SW)'(dif);
        p_out = (2*SW+1)'(i_mid_data.base) * (2*SW+1)'(sum);
    end

    logic          r_bv   [0:QW];
    logic [RW-1:0] r_rin  [0:QW];
    logic [RW-1:0] r_rout [0:QW];
    logic [QW-1:0] r_qin  [0:QW];
    logic [QW-1:0] r_qout [0:QW];
    logic [15:0]   r_d    [0:QW];
    logic [SW-1:0] r_base [0:QW];
    t_mode         r_mode [0:QW];
    logic          r_pos  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_bv[k] <= 1'b0;
            end
        end else begin
            r_bv[0] <= o_mid_pop;
            for (int k = 0; k < QW; k++) begin
                r_bv[k+1] <= r_bv[k];
            end
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    always_ff @(posedge i_clk) begin
        r_rin[0]  <= RW'({p_in, 1'b0}) + RW'(i_cfg.soft_thr);
        r_rout[0] <= RW'({p_out, 1'b0}) + RW'(i_cfg.soft_thr);
        r_qin[0]  <= '0;
        r_qout[0] <= '0;
        r_d[0]    <= {i_cfg.soft_thr, 1'b0};
        r_base[0] <= i_mid_data.base;
        r_mode[0] <= i_mid_data.mode;
        r_pos[0]  <= i_mid_data.pos;
        for (int k = 0; k < QW; k++) begin
            if (r_rin[k] >= (RW'(r_d[k]) << (QW-1-k))) begin
                r_rin[k+1] <= r_rin[k] - (RW'(r_d[k]) << (QW-1-k));
                r_qin[k+1] <= r_qin[k] | (QW'(1) << (QW-1-k));
            end else begin
                r_rin[k+1] <= r_rin[k];
                r_qin[k+1] <= r_qin[k];
            end
            if (r_rout[k] >= (RW'(r_d[k]) << (QW-1-k))) begin
                r_rout[k+1] <= r_rout[k] - (RW'(r_d[k]) << (QW-1-k));
                r_qout[k+1] <= r_qout[k] | (QW'(1) << (QW-1-k));
            end else begin
                r_rout[k+1] <= r_rout[k];
                r_qout[k+1] <= r_qout[k];
            end
            r_d[k+1]    <= r_d[k];
            r_base[k+1] <= r_base[k];
            r_mode[k+1] <= r_mode[k];
            r_pos[k+1]  <= r_pos[k];
        end
    end

    // pick wheel speeds, clamp, swap by turn side
    logic signed [15:0] maxs, inner, outer;
    t_res res;

    always_comb begin
        maxs = signed'({1'b0, i_cfg.max_speed});
        case (r_mode[QW])
            MODE_STRAIGHT: begin
                inner = signed'({1'b0, r_base[QW]});
                outer = signed'({1'b0, r_base[QW]});
            end
            MODE_SOFT: begin
                inner = (r_qin[QW] > 16'(i_cfg.max_speed)) ? maxs : signed'(r_qin[QW]);
                outer = (r_qout[QW] > 16'(i_cfg.max_speed)) ? maxs : signed'(r_qout[QW]);
            end
            default: begin
                inner = -maxs;
                outer = maxs;
            end
        endcase
        res.left  = r_pos[QW] ? inner : outer;
        res.right = r_pos[QW] ? outer : inner;
        res.mode  = r_mode[QW];
    end

    // output queue
    t_res r_omem [0:OUT_DEPTH-1];
    logic [OUT_AW-1:0] r_owp, r_orp, n_orp;
    logic [OUT_CW-1:0] r_ocnt;
    logic opush;
    t_res r_ordata;

    assign opush   = r_bv[QW];
    assign empty   = (r_ocnt == '0);
    assign out_pop = pop && !empty;
    assign n_orp   = out_pop ? r_orp + OUT_AW'(1) : r_orp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (opush) begin
                r_owp <= r_owp + OUT_AW'(1);
            end
            r_orp  <= n_orp;
            r_ocnt <= r_ocnt + OUT_CW'(opush) - OUT_CW'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_omem[r_owp] <= res;
        end
        // prefetch the next head; a write into that slot goes straight through
        if (opush && (r_owp == n_orp)) begin
            r_ordata <= res;
        end else begin
            r_ordata <= r_omem[n_orp];
        end
    end

    assign o_left_speed  = r_ordata.left;
    assign o_right_speed = r_ordata.right;
    assign o_turn_mode   = r_ordata.mode;

    `HWS_ASSERT(a_out_no_overflow, opush, r_ocnt != OUT_CW'(OUT_DEPTH))
    `HWS_ALWAYS(a_credit_bound, r_bcnt <= OUT_CW'(OUT_DEPTH))
    `HWS_ALWAYS(a_queue_within_credit, r_ocnt <= r_bcnt)
    `HWS_ASSERT(a_soft_order, r_bv[QW] && (r_mode[QW] == MODE_SOFT), r_qin[QW] <= r_qout[QW])

endmodule

`default_nettype wire

>>> src/heading_to_wheel_speeds.sv
`timescale 1ns / 1ps
`default_nettype none
// Differential-drive wheel speeds from a heading vector.
// Input channel: drive i_heading_x/i_heading_y with push; a request is taken
// on a clock edge with push high and full low. Results: while empty is low,
// o_left_speed, o_right_speed and o_turn_mode show the oldest result; pop
// takes it. Results leave in request order, one per request.
// Configuration: i_cfg_valid with i_cfg_index/i_cfg_data; o_cfg_ready is
// always high. Write only while no request is in flight.
// Path: the angle/length front end (entry register, CORDIC stages, product
// register) feeds a 32-entry queue, then the turn divider feeds a 32-entry
// result queue. Throughput: one request per cycle while full is low, set by
// the fully pipelined CORDIC and the one-bit-per-stage divider. Each side
// holds credits for its queue, so when pop stays low the result queue fills,
// the divider stops taking entries, and full rises once the front queue is
// taken up as well.
// Reset (synchronous, i_rst_n low): queues empty, registers back to
// max speed 2560, no-turn threshold 1430, soft-turn threshold 10008.
module heading_to_wheel_speeds import hws_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] i_heading_x,
    input  wire logic signed [15:0] i_heading_y,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      o_left_speed,
    output logic signed [15:0]      o_right_speed,
    output logic [1:0]              o_turn_mode
);

    t_cfg r_cfg;
    logic mid_push, mid_pop, mid_empty;
    t_mid mid_wdata, mid_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed <= SW'(2560);
            r_cfg.no_turn   <= SW'(1430);
            r_cfg.soft_thr  <= SW'(10008);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_SPEED: r_cfg.max_speed <= i_cfg_data[SW-1:0];
                CFG_NO_TURN:   r_cfg.no_turn   <= i_cfg_data[SW-1:0];
                CFG_SOFT_THR:  r_cfg.soft_thr  <= i_cfg_data[SW-1:0];
                default: begin
                    // unmapped index: drop
                end
            endcase
        end
    end

    hws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .push        (push),
        .full        (full),
        .i_heading_x (i_heading_x),
        .i_heading_y (i_heading_y),
        .o_mid_push  (mid_push),
        .o_mid_data  (mid_wdata),
        .i_mid_pop   (mid_pop)
    );

    hws_mid_q u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_rdata)
    );

    hws_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_mid_empty   (mid_empty),
        .i_mid_data    (mid_rdata),
        .o_mid_pop     (mid_pop),
        .pop           (pop),
        .empty         (empty),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed),
        .o_turn_mode   (o_turn_mode)
    );

endmodule

`default_nettype wire
